### sv/coordinate_message_parser_top_defines.svh
// ----------------------------------------------------------------------------
// Coordinate message parser: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_MESSAGE_PARSER_TOP_DEFINES_SVH
`define COORDINATE_MESSAGE_PARSER_TOP_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define CMP_ASSERT_ALWAYS(label, clk_sig, rst_n_sig, cond, text) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond)) \
		else $error(text);

// Check that a consequence holds in the same cycle as its antecedent.
`define CMP_ASSERT_IMPLY(label, clk_sig, rst_n_sig, ante, cons, text) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error(text);

`endif

### sv/cmp_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate message parser package
// Widths, character codes, token types and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cmp_pkg;

	localparam int BYTE_W              = 8;
	localparam int VALUE_W             = 32;
	localparam int MAG_W               = 31;
	localparam int DIGIT_W             = 4;
	localparam int POW_W               = 20;
	localparam int EXP_W               = 3;
	localparam int MIN_TEXT            = 6;
	localparam int TEXT_LEN_W          = 3;
	localparam int QUEUE_DEPTH         = 4;
	localparam int MAX_FIELD_CHARS_DEF = 31;
	localparam int FRACTION_DIGITS_DEF = 3;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_D0    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_D9    = 8'h39;

	typedef enum logic [2:0] {
		TK_SKIP,
		TK_AT,
		TK_COMMA,
		TK_SLASH,
		TK_MINUS,
		TK_POINT,
		TK_DIGIT,
		TK_OTHER
	} tok_class_t;

	typedef struct packed {
		tok_class_t         cls;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} token_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_XF,
		PH_YF,
		PH_TAIL
	} phase_t;

	// Ten to the power n, n from 0 to 6.
	function automatic logic [POW_W-1:0] pow10_f(input logic [EXP_W-1:0] n);
		logic [POW_W-1:0] p;
		unique case (n)
			3'd0:    p = 20'd1;
			3'd1:    p = 20'd10;
			3'd2:    p = 20'd100;
			3'd3:    p = 20'd1000;
			3'd4:    p = 20'd10000;
			3'd5:    p = 20'd100000;
			3'd6:    p = 20'd1000000;
			default: p = 20'd0;
		endcase
		return p;
	endfunction

	// m * 10 + d, saturated to MAG_MAX.
	function automatic logic [MAG_W-1:0] times_ten_plus_f(input logic [MAG_W-1:0] m,
		input logic [DIGIT_W-1:0] d);
		logic [MAG_W+3:0] v;
		v = (MAG_W+4)'({m, 3'b000}) + (MAG_W+4)'({m, 1'b0}) + (MAG_W+4)'(d);
		return (v > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : v[MAG_W-1:0];
	endfunction

	// m * p, saturated to MAG_MAX.
	function automatic logic [MAG_W-1:0] scale_sat_f(input logic [MAG_W-1:0] m,
		input logic [POW_W-1:0] p);
		logic [MAG_W+POW_W-1:0] prod;
		prod = (MAG_W+POW_W)'(m) * (MAG_W+POW_W)'(p);
		return (prod > (MAG_W+POW_W)'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
	endfunction

	// Apply the sign to a magnitude.
	function automatic logic signed [VALUE_W-1:0] to_signed_f(input logic neg,
		input logic [MAG_W-1:0] mag);
		logic signed [VALUE_W-1:0] v;
		v = $signed({1'b0, mag});
		return neg ? -v : v;
	endfunction

endpackage

`default_nettype wire

### sv/cmp_stream_if.sv
// ----------------------------------------------------------------------------
// Coordinate message parser channels
// Valid/ready channels for message bytes and for parse results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmp_in_if;
	import cmp_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              end_of_buffer;

	modport source (output valid, output rx_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface cmp_out_if;
	import cmp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic signed [VALUE_W-1:0] x_value;
	logic signed [VALUE_W-1:0] y_value;

	modport source (output valid, output accepted, output x_value, output y_value,
		input ready);
	modport sink   (input valid, input accepted, input x_value, input y_value,
		output ready);
endinterface

`default_nettype wire

### sv/cmp_front.sv
// ----------------------------------------------------------------------------
// Coordinate message parser front end
// Accepts bytes, classifies each into a token and pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cmp_front
	import cmp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	cmp_in_if.sink     msg,
	input  q_status_t  q_stat,
	output logic       push,
	output token_t     wr_token
);

	logic       ended_q;
	tok_class_t cls;

	assign msg.ready = !q_stat.full;
	assign push      = msg.valid && !q_stat.full;

	// Zero ends the text; drop everything after it until the buffer ends.
	always_comb begin
		if (ended_q || msg.rx_byte == CH_NUL) begin
			cls = TK_SKIP;
		end else begin
			unique case (msg.rx_byte) inside
				CH_AT:          cls = TK_AT;
				CH_COMMA:       cls = TK_COMMA;
				CH_SLASH:       cls = TK_SLASH;
				CH_MINUS:       cls = TK_MINUS;
				CH_POINT:       cls = TK_POINT;
				[CH_D0:CH_D9]:  cls = TK_DIGIT;
				default:        cls = TK_OTHER;
			endcase
		end
	end

	assign wr_token.cls   = cls;
	assign wr_token.digit = DIGIT_W'(msg.rx_byte - CH_D0);
	assign wr_token.last  = msg.end_of_buffer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (push) begin
			if (msg.end_of_buffer) begin
				ended_q <= 1'b0;
			end else if (msg.rx_byte == CH_NUL) begin
				ended_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/cmp_queue.sv
// ----------------------------------------------------------------------------
// Coordinate message parser token queue
// Short FIFO that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module cmp_queue
	import cmp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  token_t     wr_token,
	input  wire logic  pop,
	output token_t     rd_token,
	output q_status_t  q_stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	token_t           slots [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign q_stat.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign rd_token     = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= wr_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/cmp_back.sv
// ----------------------------------------------------------------------------
// Coordinate message parser back end
// Runs the message grammar on tokens, evaluates at buffer end, holds result.
// ----------------------------------------------------------------------------
`default_nettype none

module cmp_back
	import cmp_pkg::*;
#(
	parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF,
	parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  token_t     rd_token,
	input  q_status_t  q_stat,
	output logic       pop,
	cmp_out_if.source  result
);

	localparam int FLEN_W  = $clog2(MAX_FIELD_CHARS + 1);
	localparam int TAKEN_W = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;

	// Per-message parse state
	phase_t                phase_q, phase_n;
	logic [TEXT_LEN_W-1:0] len_q, len_n;
	logic [FLEN_W-1:0]     flen_q, flen_n;
	logic                  neg_q, neg_n;
	logic                  point_q, point_n;
	logic [TAKEN_W-1:0]    taken_q, taken_n;
	logic [MAG_W-1:0]      acc_q, acc_n;
	logic                  ok_q, ok_n;

	// Finished field magnitudes
	logic [MAG_W-1:0]      x_mag_q, y_mag_q;
	logic                  x_neg_q, y_neg_q;
	logic                  x_ld, y_ld;

	// Evaluation stage and output register
	logic                  eval_v_s1, eval_ok_s1;
	logic                  eval_set, eval_ok;
	logic                  s2_load, s1_free;
	logic                  out_v_q, out_acc_q;
	logic signed [VALUE_W-1:0] out_x_q, out_y_q;

	logic [MAG_W-1:0]      ttp;
	logic [MAG_W-1:0]      scaled;
	logic [EXP_W-1:0]      exp10;
	logic                  complete;

	assign s2_load = eval_v_s1 && (!out_v_q || result.ready);
	assign s1_free = !eval_v_s1 || s2_load;
	assign pop     = !q_stat.empty && s1_free;

	assign ttp      = times_ten_plus_f(acc_q, rd_token.digit);
	assign exp10    = EXP_W'(FRACTION_DIGITS) - EXP_W'(taken_q);
	assign scaled   = scale_sat_f(acc_q, pow10_f(exp10));
	assign complete = (flen_q != '0) && !(neg_q && flen_q == FLEN_W'(1));

	always_comb begin
		logic field_step;
		field_step = 1'b0;
		phase_n    = phase_q;
		len_n      = len_q;
		flen_n     = flen_q;
		neg_n      = neg_q;
		point_n    = point_q;
		taken_n    = taken_q;
		acc_n      = acc_q;
		ok_n       = ok_q;
		x_ld       = 1'b0;
		y_ld       = 1'b0;
		eval_set   = 1'b0;
		eval_ok    = 1'b0;
		if (pop) begin
			if (rd_token.cls != TK_SKIP) begin
				if (len_q < TEXT_LEN_W'(MIN_TEXT)) begin
					len_n = len_q + 1'b1;
				end
				if (ok_q) begin
					unique case (phase_q)
						PH_START: begin
							if (rd_token.cls == TK_AT) begin
								phase_n = PH_XF;
							end else begin
								ok_n = 1'b0;
							end
						end
						PH_XF: begin
							if (rd_token.cls == TK_COMMA) begin
								if (!complete) begin
									ok_n = 1'b0;
								end else begin
									x_ld    = 1'b1;
									phase_n = PH_YF;
									flen_n  = '0;
									neg_n   = 1'b0;
									point_n = 1'b0;
									taken_n = '0;
									acc_n   = '0;
								end
							end else if (rd_token.cls == TK_SLASH) begin
								ok_n = 1'b0;
							end else begin
								field_step = 1'b1;
							end
						end
						PH_YF: begin
							if (rd_token.cls == TK_SLASH) begin
								if (!complete) begin
									ok_n = 1'b0;
								end else begin
									y_ld    = 1'b1;
									phase_n = PH_TAIL;
								end
							end else begin
								field_step = 1'b1;
							end
						end
						PH_TAIL: begin
						end
						default: begin
						end
					endcase
					if (field_step) begin
						if (flen_q >= FLEN_W'(MAX_FIELD_CHARS)) begin
							ok_n = 1'b0;
						end else begin
							unique case (rd_token.cls)
								TK_MINUS: begin
									if (flen_q == '0) begin
										neg_n  = 1'b1;
										flen_n = flen_q + 1'b1;
									end else begin
										ok_n = 1'b0;
									end
								end
								TK_POINT: begin
									if (point_q) begin
										ok_n = 1'b0;
									end else begin
										point_n = 1'b1;
										flen_n  = flen_q + 1'b1;
									end
								end
								TK_DIGIT: begin
									// Drop fraction digits beyond the fixed-point scale.
									if (!point_q) begin
										acc_n = ttp;
									end else if (taken_q < TAKEN_W'(FRACTION_DIGITS)) begin
										acc_n   = ttp;
										taken_n = taken_q + 1'b1;
									end
									flen_n = flen_q + 1'b1;
								end
								default: ok_n = 1'b0;
							endcase
						end
					end
				end
			end
			if (rd_token.last) begin
				eval_set = 1'b1;
				eval_ok  = ok_n && (phase_n == PH_TAIL) && (len_n >= TEXT_LEN_W'(MIN_TEXT));
				phase_n  = PH_START;
				len_n    = '0;
				flen_n   = '0;
				neg_n    = 1'b0;
				point_n  = 1'b0;
				taken_n  = '0;
				acc_n    = '0;
				ok_n     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			len_q   <= '0;
			flen_q  <= '0;
			neg_q   <= 1'b0;
			point_q <= 1'b0;
			taken_q <= '0;
			acc_q   <= '0;
			ok_q    <= 1'b1;
		end else begin
			phase_q <= phase_n;
			len_q   <= len_n;
			flen_q  <= flen_n;
			neg_q   <= neg_n;
			point_q <= point_n;
			taken_q <= taken_n;
			acc_q   <= acc_n;
			ok_q    <= ok_n;
		end
	end

	always_ff @(posedge clk) begin
		if (x_ld) begin
			x_mag_q <= scaled;
			x_neg_q <= neg_q;
		end
		if (y_ld) begin
			y_mag_q <= scaled;
			y_neg_q <= neg_q;
		end
		if (eval_set) begin
			eval_ok_s1 <= eval_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
			out_acc_q <= 1'b0;
			out_x_q   <= '0;
			out_y_q   <= '0;
		end else begin
			if (eval_set) begin
				eval_v_s1 <= 1'b1;
			end else if (s2_load) begin
				eval_v_s1 <= 1'b0;
			end
			if (s2_load) begin
				out_v_q   <= 1'b1;
				out_acc_q <= eval_ok_s1;
				// A rejected message keeps the held pair.
				if (eval_ok_s1) begin
					out_x_q <= to_signed_f(x_neg_q, x_mag_q);
					out_y_q <= to_signed_f(y_neg_q, y_mag_q);
				end
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result.valid    = out_v_q;
	assign result.accepted = out_acc_q;
	assign result.x_value  = out_x_q;
	assign result.y_value  = out_y_q;

endmodule

`default_nettype wire

### sv/coordinate_message_parser_top.sv
// ----------------------------------------------------------------------------
// Coordinate message parser
// Checks byte messages of the form "@x,y/" and keeps the last good x, y pair
// in signed fixed point, units of 1/1000 by default. Bytes enter one per
// clock with no gaps needed: a classifier tags each byte, a four-entry token
// queue carries it to the parser, and the parser consumes one token per
// cycle. The byte flagged end_of_buffer yields one result (accepted flag and
// the held pair), registered through the token queue, the evaluation stage
// and the output register. Sustained rate is one byte per cycle, set by the
// parser's single-token step; a stalled result channel holds the parser
// and, once the queue fills, the input. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coordinate_message_parser_top_defines.svh"

module coordinate_message_parser_top
	import cmp_pkg::*;
#(
	parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF,
	parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cmp_in_if.sink     msg,
	cmp_out_if.source  result
);

	// Token path from classifier through the queue to the parser
	token_t    wr_token;
	token_t    rd_token;
	logic      q_push;
	logic      q_pop;
	q_status_t q_stat;

	// Classify each byte; stop taking bytes when the queue is full.
	cmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg),
		.q_stat   (q_stat),
		.push     (q_push),
		.wr_token (wr_token)
	);

	// Hold tokens so either side can stall without stopping the other.
	cmp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_token (wr_token),
		.pop      (q_pop),
		.rd_token (rd_token),
		.q_stat   (q_stat)
	);

	// Parse, evaluate at buffer end and drive the result transaction.
	cmp_back #(
		.MAX_FIELD_CHARS (MAX_FIELD_CHARS),
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_token (rd_token),
		.q_stat   (q_stat),
		.pop      (q_pop),
		.result   (result)
	);

	// Input readiness follows queue space only.
	`CMP_ASSERT_ALWAYS(a_ready_tracks_queue, clk, arst_n, msg.ready == !q_stat.full, "input ready disagrees with queue space")

	// The parser never takes a token from an empty queue.
	`CMP_ASSERT_ALWAYS(a_no_pop_empty, clk, arst_n, !(q_pop && q_stat.empty), "token popped from empty queue")

	// Saturation keeps both values off the most negative code.
	`CMP_ASSERT_IMPLY(a_values_saturated, clk, arst_n, result.valid, (result.x_value != 32'sh8000_0000) && (result.y_value != 32'sh8000_0000), "held value outside saturation range")

endmodule

`default_nettype wire

### tb/sv/tb_coordinate_message_parser_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Coordinate message parser testbench
// Streams "@x,y/" messages byte by byte into the parser and tracks the held
// x, y pair with a behavioral copy of the parse rules. The stimulus runs in
// three parts. Short directed messages come first. A long hold-off on the
// result side follows, which backs up the byte input. Last comes a random
// mix of well-formed, damaged and noise messages. Both channels idle at
// random except during the hold-off.
// ----------------------------------------------------------------------------

module tb_coordinate_message_parser_top;
	import cmp_pkg::*;

	localparam int FRAC_DIGITS  = FRACTION_DIGITS_DEF;
	localparam int FIELD_MAX    = MAX_FIELD_CHARS_DEF;
	localparam int RANDOM_BYTES = 1500;
	localparam int LONG_HOLD    = 240;
	localparam int DRAIN_CYCLES = 20;

	typedef logic [BYTE_W-1:0] char_t;

	// One evaluation of a buffer: accept flag plus the held pair afterwards.
	typedef struct packed {
		logic                      accepted;
		logic signed [VALUE_W-1:0] x_value;
		logic signed [VALUE_W-1:0] y_value;
	} pair_report_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cmp_in_if  msg_ch ();
	cmp_out_if res_ch ();

	coordinate_message_parser_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.result (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Tracked parser state, one copy for the whole run.
	phase_t                    parse_phase;
	logic [2:0]                text_len;
	logic [5:0]                fld_len;
	logic                      fld_neg;
	logic                      fld_point;
	logic [1:0]                fld_frac;
	logic [MAG_W-1:0]          fld_mag;
	logic                      msg_ok;
	logic                      text_done;
	logic signed [VALUE_W-1:0] pend_x;
	logic signed [VALUE_W-1:0] held_x;
	logic signed [VALUE_W-1:0] held_y;

	// Reports due from the block, oldest first.
	pair_report_t pair_reports_due[$];

	int error_count  = 0;
	bit tx_gaps      = 1'b1;
	bit rx_stalls    = 1'b1;
	bit hold_results = 1'b0;

	// ------------------------------------------------------------------------
	// Parse tracking
	// ------------------------------------------------------------------------

	// Shift a decimal digit into a magnitude; clamp at the largest magnitude.
	function automatic logic [MAG_W-1:0] mag_shift_in(input logic [MAG_W-1:0] m,
		input logic [DIGIT_W-1:0] d);
		logic [MAG_W+3:0] wide;
		wide = (MAG_W+4)'(m) * 10 + (MAG_W+4)'(d);
		return (wide > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : wide[MAG_W-1:0];
	endfunction

	// Scale the field to thousandths (pad missing fraction digits), then sign it.
	function automatic logic signed [VALUE_W-1:0] field_fixed();
		logic [MAG_W-1:0] m;
		int               k;
		m = fld_mag;
		for (k = fld_frac; k < FRAC_DIGITS; k++)
			m = mag_shift_in(m, '0);
		return fld_neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic field_done();
		return (fld_len != 0) && !(fld_neg && fld_len == 1);
	endfunction

	function automatic void clear_field();
		fld_len   = '0;
		fld_neg   = 1'b0;
		fld_point = 1'b0;
		fld_frac  = '0;
		fld_mag   = '0;
	endfunction

	function automatic void clear_message();
		parse_phase = PH_START;
		text_len    = '0;
		msg_ok      = 1'b1;
		text_done   = 1'b0;
		pend_x      = '0;
		clear_field();
	endfunction

	function automatic void field_char(input char_t c);
		if (fld_len >= FIELD_MAX) begin
			msg_ok = 1'b0;
			return;
		end
		if (c == CH_MINUS && fld_len == 0) begin
			fld_neg = 1'b1;
		end else if (c == CH_POINT) begin
			if (fld_point) begin
				msg_ok = 1'b0;
				return;
			end
			fld_point = 1'b1;
		end else if (c >= CH_D0 && c <= CH_D9) begin
			// Drop fraction digits past the third; they still count as characters.
			if (!fld_point) begin
				fld_mag = mag_shift_in(fld_mag, DIGIT_W'(c - CH_D0));
			end else if (fld_frac < FRAC_DIGITS) begin
				fld_mag  = mag_shift_in(fld_mag, DIGIT_W'(c - CH_D0));
				fld_frac = fld_frac + 1'b1;
			end
		end else begin
			msg_ok = 1'b0;
			return;
		end
		fld_len = fld_len + 1'b1;
	endfunction

	function automatic void text_char(input char_t c);
		if (text_len < MIN_TEXT)
			text_len = text_len + 1'b1;
		if (!msg_ok)
			return;
		case (parse_phase)
			PH_START: begin
				if (c == CH_AT)
					parse_phase = PH_XF;
				else
					msg_ok = 1'b0;
			end
			PH_XF: begin
				if (c == CH_COMMA) begin
					if (!field_done()) begin
						msg_ok = 1'b0;
					end else begin
						pend_x = field_fixed();
						clear_field();
						parse_phase = PH_YF;
					end
				end else if (c == CH_SLASH) begin
					msg_ok = 1'b0;
				end else begin
					field_char(c);
				end
			end
			PH_YF: begin
				if (c == CH_SLASH) begin
					if (!field_done())
						msg_ok = 1'b0;
					else
						parse_phase = PH_TAIL;
				end else begin
					field_char(c);
				end
			end
			default: ;
		endcase
	endfunction

	// Advance the tracked state by one accepted byte; the last byte of a
	// buffer queues the report the block must produce.
	function automatic void track_byte(input char_t c, input logic eob);
		logic ok;
		if (!text_done) begin
			if (c == CH_NUL)
				text_done = 1'b1;
			else
				text_char(c);
		end
		if (!eob)
			return;
		ok = msg_ok && parse_phase == PH_TAIL && text_len >= MIN_TEXT;
		if (ok) begin
			held_x = pend_x;
			held_y = field_fixed();
		end
		pair_reports_due.push_back('{accepted: ok, x_value: held_x, y_value: held_y});
		clear_message();
	endfunction

	// ------------------------------------------------------------------------
	// Byte source
	// ------------------------------------------------------------------------

	// Offer one byte after a random gap, hold it until the transaction, then
	// advance the tracked state. Valid stays high when no gap is drawn.
	task automatic send_byte(input char_t c, input logic eob);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid         <= 1'b1;
		msg_ch.rx_byte       <= c;
		msg_ch.end_of_buffer <= eob;
		do @(posedge clk); while (msg_ch.ready !== 1'b1);
		track_byte(c, eob);
	endtask

	// Send a whole buffer; flag its last byte.
	task automatic send_message(input char_t bytes[$]);
		int i;
		for (i = 0; i < bytes.size(); i++)
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	function automatic void append_text(ref char_t q[$], input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			q.push_back(char_t'(s[i]));
	endfunction

	task automatic send_text(input string s);
		char_t bytes[$];
		append_text(bytes, s);
		send_message(bytes);
	endtask

	// ------------------------------------------------------------------------
	// Random message pieces
	// ------------------------------------------------------------------------

	// Lean on nines so that long integer parts reach saturation.
	function automatic char_t rand_digit();
		return ($urandom_range(0, 3) == 0) ? CH_D9 : char_t'(CH_D0 + $urandom_range(0, 9));
	endfunction

	function automatic char_t special_char();
		case ($urandom_range(0, 6))
			0:       return CH_AT;
			1:       return CH_COMMA;
			2:       return CH_SLASH;
			3:       return CH_MINUS;
			4:       return CH_POINT;
			5:       return CH_NUL;
			default: return char_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Append one number field: mostly ordinary, sometimes empty, a lone sign,
	// a bare point, or around the length limit.
	function automatic void append_field(ref char_t q[$]);
		int len;
		int point_at;
		int i;
		case ($urandom_range(0, 19))
			0: ;
			1: q.push_back(CH_MINUS);
			2: begin
				if ($urandom_range(0, 1) != 0)
					q.push_back(CH_MINUS);
				q.push_back(CH_POINT);
			end
			3: begin
				len      = $urandom_range(FIELD_MAX - 1, FIELD_MAX + 1);
				point_at = $urandom_range(0, len);
				for (i = 0; i < len; i++)
					q.push_back(i == point_at ? CH_POINT : rand_digit());
			end
			default: begin
				if ($urandom_range(0, 3) == 0)
					q.push_back(CH_MINUS);
				len      = $urandom_range(1, 10);
				point_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : len;
				for (i = 0; i < len; i++)
					q.push_back(i == point_at ? CH_POINT : rand_digit());
			end
		endcase
	endfunction

	// "@x,y/" and a short tail that sometimes holds a zero byte.
	function automatic void append_coord_message(ref char_t q[$]);
		int i;
		q.push_back(CH_AT);
		append_field(q);
		q.push_back(CH_COMMA);
		append_field(q);
		q.push_back(CH_SLASH);
		for (i = $urandom_range(0, 3); i > 0; i--)
			q.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : char_t'($urandom_range(1, 255)));
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Six characters is the floor; a tail byte lifts "@1,2/" to it.
	task automatic test_length_rule();
		char_t bytes[$];
		send_text("@1,2/");
		append_text(bytes, "@1,2/");
		bytes.push_back(8'hFF);
		send_message(bytes);
	endtask

	// Bare point with sign, extra fraction digits, minus zero, lone minus.
	task automatic test_field_forms();
		send_text("@-.,.9999/");
		send_text("@0,-0/");
		send_text("@-,1/x");
	endtask

	// Minus inside a field, slash before comma, double point, no slash.
	task automatic test_malformed();
		send_text("@1-2,3/");
		send_text("@1/2,3/");
		send_text("@1..2,3/");
		send_text("@12,34!");
	endtask

	// Both fields clamp, one at each sign.
	task automatic test_saturation();
		send_text("@9999999,-9999999/");
	endtask

	// A zero byte ends the text; whatever follows it is ignored.
	task automatic test_zero_byte();
		char_t bytes[$];
		append_text(bytes, "@1,2");
		bytes.push_back(CH_NUL);
		append_text(bytes, "/zz");
		send_message(bytes);
		bytes = {};
		append_text(bytes, "@7,8/9");
		bytes.push_back(CH_NUL);
		append_text(bytes, "@x");
		send_message(bytes);
	endtask

	// Hold the result side for a long stretch while bytes keep coming, so the
	// token queue fills and the input stalls.
	task automatic test_backpressure();
		char_t bytes[$];
		int    n;
		tx_gaps      = 1'b0;
		rx_stalls    = 1'b0;
		hold_results = 1'b1;
		for (n = 0; n < 8; n++) begin
			bytes = {};
			append_coord_message(bytes);
			send_message(bytes);
		end
	endtask

	// Mostly well-formed messages with random content, some damaged by one
	// replaced or removed byte, the rest plain noise. Redraw the idling mode
	// now and then so that both busy and sparse stretches occur.
	task automatic test_random_messages();
		char_t bytes[$];
		int    sent;
		int    count;
		int    kind;
		int    idx;
		sent  = 0;
		count = 0;
		while (sent < RANDOM_BYTES) begin
			if (count % 25 == 0) begin
				tx_gaps   = $urandom_range(0, 3) != 0;
				rx_stalls = $urandom_range(0, 3) != 0;
			end
			bytes = {};
			kind  = $urandom_range(0, 19);
			if (kind < 17) begin
				append_coord_message(bytes);
				if (kind >= 14) begin
					idx = $urandom_range(0, bytes.size() - 1);
					if ($urandom_range(0, 2) == 0)
						bytes.delete(idx);
					else
						bytes[idx] = special_char();
				end
			end else begin
				repeat ($urandom_range(1, 10))
					bytes.push_back(char_t'($urandom_range(0, 255)));
			end
			send_message(bytes);
			sent  += bytes.size();
			count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result sink: random stalls per result, plus the long hold on request.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		int held;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				res_ch.ready <= 1'b0;
				for (held = 0; held < LONG_HOLD; held++)
					@(posedge clk);
				hold_results = 1'b0;
			end
			stall = rx_stalls ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	// ------------------------------------------------------------------------
	// Result check: compare each result transaction with the oldest report due.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : report_check
		pair_report_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pair_reports_due.size() == 0) begin
				$error("unexpected result: accepted=%0d x_value=%0d y_value=%0d",
					res_ch.accepted, res_ch.x_value, res_ch.y_value);
				error_count++;
			end else begin
				want = pair_reports_due.pop_front();
				if (res_ch.accepted !== want.accepted) begin
					$error("accepted: expected %0d, actual %0d", want.accepted, res_ch.accepted);
					error_count++;
				end
				if (res_ch.x_value !== want.x_value) begin
					$error("x_value: expected %0d, actual %0d", want.x_value, res_ch.x_value);
					error_count++;
				end
				if (res_ch.y_value !== want.y_value) begin
					$error("y_value: expected %0d, actual %0d", want.y_value, res_ch.y_value);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : test_sequence
		msg_ch.valid         <= 1'b0;
		msg_ch.rx_byte       <= '0;
		msg_ch.end_of_buffer <= 1'b0;
		clear_message();
		held_x = '0;
		held_y = '0;

		// Hold reset, then release it away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_length_rule();
		test_field_forms();
		test_malformed();
		test_saturation();
		test_zero_byte();
		test_backpressure();
		test_random_messages();
		msg_ch.valid <= 1'b0;

		// Drain the reports due, then watch a little longer for strays.
		while (pair_reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("coordinate_message_parser_top verification clean");
		else
			$display("coordinate_message_parser_top verification failed");
		$finish;
	end

	// Timeout: far beyond the slowest legal run.
	initial begin : run_limit
		#4_000_000;
		$display("coordinate_message_parser_top verification failed");
		$finish;
	end

endmodule
